// File: src/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, operation codes and round/saturate helpers for the
// quaternion arithmetic unit (signed fixed point, WORD_BITS wide).
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int WORD_BITS     = 16;
  localparam int FRACTION_BITS = 12;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  // four products plus doubling and rounding headroom
  localparam int ACC_BITS      = 2 * WORD_BITS + 3;

  localparam int IDX_X = 0;
  localparam int IDX_Y = 1;
  localparam int IDX_Z = 2;
  localparam int IDX_W = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_SUB    = 3'd1,
    FUNC_MUL    = 3'd2,
    FUNC_SCALE  = 3'd3,
    FUNC_ROTATE = 3'd4,
    FUNC_CONJ   = 3'd5,
    FUNC_DOT    = 3'd6
  } func_e;

  localparam acc_t  ACC_MAX  = acc_t'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam acc_t  ACC_MIN  = -ACC_MAX - acc_t'(1);
  localparam acc_t  ACC_HALF = acc_t'(64'sd1 <<< (FRACTION_BITS - 1));
  localparam word_t WORD_MAX = word_t'(ACC_MAX);
  localparam word_t WORD_MIN = word_t'(ACC_MIN);

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  // Mid-pipe request: first-half results plus rotate operands.
  typedef struct packed {
    func_e func;
    logic  ovf;
    word_t res_x;
    word_t res_y;
    word_t res_z;
    word_t res_w;
    word_t c_x;
    word_t c_y;
    word_t c_z;
    word_t q_x;
    word_t q_y;
    word_t q_z;
    word_t q_w;
    word_t v_x;
    word_t v_y;
    word_t v_z;
  } mid_t;

  typedef struct packed {
    logic  ovf;
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } res_t;

  // Drop the fraction bits, ties toward plus infinity.
  function automatic acc_t round_frac(acc_t acc);
    return (acc + ACC_HALF) >>> FRACTION_BITS;
  endfunction

  function automatic sat_t sat_word(acc_t acc);
    sat_t s;
    if (acc > ACC_MAX) begin
      s.ovf = 1'b1;
      s.val = WORD_MAX;
    end else if (acc < ACC_MIN) begin
      s.ovf = 1'b1;
      s.val = WORD_MIN;
    end else begin
      s.ovf = 1'b0;
      s.val = word_t'(acc);
    end
    return s;
  endfunction

endpackage

// File: src/quaternion_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Q4.12 quaternion unit: add, sub, Hamilton product, scale, rotate, conjugate,
// dot. Every op passes the same four register stages (B, C, D, E), and its
// result leaves the last one together with a done_o strobe.
// Throughput: one request per cycle; busy is always low since the pipe
// never stalls and the receiver cannot hold results off.
// Reset: async active-low, clears the stage valid bits only (no flush pass).
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_core
  import qau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic signed [WORD_BITS-1:0] a_x_i,
  input  logic signed [WORD_BITS-1:0] a_y_i,
  input  logic signed [WORD_BITS-1:0] a_z_i,
  input  logic signed [WORD_BITS-1:0] a_w_i,
  input  logic signed [WORD_BITS-1:0] b_x_i,
  input  logic signed [WORD_BITS-1:0] b_y_i,
  input  logic signed [WORD_BITS-1:0] b_z_i,
  input  logic signed [WORD_BITS-1:0] b_w_i,
  output logic        done_o,
  output logic signed [WORD_BITS-1:0] r_x_o,
  output logic signed [WORD_BITS-1:0] r_y_o,
  output logic signed [WORD_BITS-1:0] r_z_o,
  output logic signed [WORD_BITS-1:0] r_w_o,
  output logic        overflow_o
);

  // Pipe map:
  //   B: register operands and all sixteen a_i*b_j products
  //   C: sums of products, round, saturate -> final result for every op but
  //      rotate; rotate gets c = q x v here (rounded and saturated)
  //   D: rotate second-level products w*c and q x c (qau_rot_tail)
  //   E: rotate sum, op select, output register (qau_rot_tail)

  word_t a_in[4];
  word_t b_in[4];
  logic  accept;

  // stage B
  logic  valid_b_q;
  func_e func_b_q;
  word_t a_b_q[4];
  word_t b_b_q[4];
  prod_t prod_b_q[4][4];

  // stage C
  acc_t  pe[4][4];
  sat_t  add_s[4];
  sat_t  sub_s[4];
  sat_t  scl_s[4];
  sat_t  neg_s[4];
  sat_t  mul_s[4];
  sat_t  crs_s[3];
  sat_t  dot_s;
  mid_t  mid_d;
  mid_t  mid_q;
  logic  valid_c_q;

  res_t  res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign a_in[IDX_X] = a_x_i;
  assign a_in[IDX_Y] = a_y_i;
  assign a_in[IDX_Z] = a_z_i;
  assign a_in[IDX_W] = a_w_i;
  assign b_in[IDX_X] = b_x_i;
  assign b_in[IDX_Y] = b_y_i;
  assign b_in[IDX_Z] = b_z_i;
  assign b_in[IDX_W] = b_w_i;

  // ---- stage B: operand capture and product array ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    func_b_q <= func_e'(func_i);
    for (int i = 0; i < 4; i++) begin
      a_b_q[i] <= a_in[i];
      b_b_q[i] <= b_in[i];
      for (int j = 0; j < 4; j++) begin
        prod_b_q[i][j] <= a_in[i] * b_in[j];
      end
    end
  end

  // ---- stage C: sums, rounding, saturation ----
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = acc_t'(prod_b_q[i][j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      add_s[i] = sat_word(acc_t'(a_b_q[i]) + acc_t'(b_b_q[i]));
      sub_s[i] = sat_word(acc_t'(a_b_q[i]) - acc_t'(b_b_q[i]));
      scl_s[i] = sat_word(round_frac(pe[i][IDX_W]));
      neg_s[i] = sat_word(-acc_t'(a_b_q[i]));
    end

    // Hamilton product a*b
    mul_s[IDX_X] = sat_word(round_frac(pe[IDX_W][IDX_X] + pe[IDX_X][IDX_W]
                                       + pe[IDX_Y][IDX_Z] - pe[IDX_Z][IDX_Y]));
    mul_s[IDX_Y] = sat_word(round_frac(pe[IDX_W][IDX_Y] - pe[IDX_X][IDX_Z]
                                       + pe[IDX_Y][IDX_W] + pe[IDX_Z][IDX_X]));
    mul_s[IDX_Z] = sat_word(round_frac(pe[IDX_W][IDX_Z] + pe[IDX_X][IDX_Y]
                                       - pe[IDX_Y][IDX_X] + pe[IDX_Z][IDX_W]));
    mul_s[IDX_W] = sat_word(round_frac(pe[IDX_W][IDX_W] - pe[IDX_X][IDX_X]
                                       - pe[IDX_Y][IDX_Y] - pe[IDX_Z][IDX_Z]));

    // c = q x v for rotate
    crs_s[IDX_X] = sat_word(round_frac(pe[IDX_Y][IDX_Z] - pe[IDX_Z][IDX_Y]));
    crs_s[IDX_Y] = sat_word(round_frac(pe[IDX_Z][IDX_X] - pe[IDX_X][IDX_Z]));
    crs_s[IDX_Z] = sat_word(round_frac(pe[IDX_X][IDX_Y] - pe[IDX_Y][IDX_X]));

    dot_s = sat_word(round_frac(pe[IDX_X][IDX_X] + pe[IDX_Y][IDX_Y]
                                + pe[IDX_Z][IDX_Z] + pe[IDX_W][IDX_W]));

    mid_d       = '0;
    mid_d.func  = func_b_q;
    mid_d.c_x   = crs_s[IDX_X].val;
    mid_d.c_y   = crs_s[IDX_Y].val;
    mid_d.c_z   = crs_s[IDX_Z].val;
    mid_d.q_x   = a_b_q[IDX_X];
    mid_d.q_y   = a_b_q[IDX_Y];
    mid_d.q_z   = a_b_q[IDX_Z];
    mid_d.q_w   = a_b_q[IDX_W];
    mid_d.v_x   = b_b_q[IDX_X];
    mid_d.v_y   = b_b_q[IDX_Y];
    mid_d.v_z   = b_b_q[IDX_Z];

    unique case (func_b_q)
      FUNC_ADD: begin
        mid_d.res_x = add_s[IDX_X].val;
        mid_d.res_y = add_s[IDX_Y].val;
        mid_d.res_z = add_s[IDX_Z].val;
        mid_d.res_w = add_s[IDX_W].val;
        mid_d.ovf   = add_s[IDX_X].ovf | add_s[IDX_Y].ovf
                    | add_s[IDX_Z].ovf | add_s[IDX_W].ovf;
      end
      FUNC_SUB: begin
        mid_d.res_x = sub_s[IDX_X].val;
        mid_d.res_y = sub_s[IDX_Y].val;
        mid_d.res_z = sub_s[IDX_Z].val;
        mid_d.res_w = sub_s[IDX_W].val;
        mid_d.ovf   = sub_s[IDX_X].ovf | sub_s[IDX_Y].ovf
                    | sub_s[IDX_Z].ovf | sub_s[IDX_W].ovf;
      end
      FUNC_MUL: begin
        mid_d.res_x = mul_s[IDX_X].val;
        mid_d.res_y = mul_s[IDX_Y].val;
        mid_d.res_z = mul_s[IDX_Z].val;
        mid_d.res_w = mul_s[IDX_W].val;
        mid_d.ovf   = mul_s[IDX_X].ovf | mul_s[IDX_Y].ovf
                    | mul_s[IDX_Z].ovf | mul_s[IDX_W].ovf;
      end
      FUNC_SCALE: begin
        mid_d.res_x = scl_s[IDX_X].val;
        mid_d.res_y = scl_s[IDX_Y].val;
        mid_d.res_z = scl_s[IDX_Z].val;
        mid_d.res_w = scl_s[IDX_W].val;
        mid_d.ovf   = scl_s[IDX_X].ovf | scl_s[IDX_Y].ovf
                    | scl_s[IDX_Z].ovf | scl_s[IDX_W].ovf;
      end
      FUNC_ROTATE: begin
        // result formed in the tail; saturating c already counts
        mid_d.ovf = crs_s[IDX_X].ovf | crs_s[IDX_Y].ovf | crs_s[IDX_Z].ovf;
      end
      FUNC_CONJ: begin
        mid_d.res_x = neg_s[IDX_X].val;
        mid_d.res_y = neg_s[IDX_Y].val;
        mid_d.res_z = neg_s[IDX_Z].val;
        mid_d.res_w = a_b_q[IDX_W];
        mid_d.ovf   = neg_s[IDX_X].ovf | neg_s[IDX_Y].ovf | neg_s[IDX_Z].ovf;
      end
      FUNC_DOT: begin
        mid_d.res_w = dot_s.val;
        mid_d.ovf   = dot_s.ovf;
      end
      default: begin
        // unused code: all-zero result
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  // ---- stages D, E: rotate tail and output register ----
  qau_rot_tail u_rot_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c_q),
    .mid_i   (mid_q),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign r_x_o      = res.x;
  assign r_y_o      = res.y;
  assign r_z_o      = res.z;
  assign r_w_o      = res.w;
  assign overflow_o = res.ovf;

`ifndef ASSERT_OFF
  // every accepted request yields a done_o strobe
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted request produced no result");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobe without a matching request");

  a_rotate_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(func_i, 4) == FUNC_ROTATE) |-> (r_w_o == '0))
    else $error("rotate result has nonzero w");

  a_dot_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(func_i, 4) == FUNC_DOT)
      |-> (r_x_o == '0 && r_y_o == '0 && r_z_o == '0))
    else $error("dot result has nonzero vector part");
`endif

endmodule

// File: src/qau_rot_tail.sv
// ----------------------------------------------------------------------------
// qau_rot_tail
// Back half of the pipe: second-level rotate products, then the rotate sum
// with round/saturate and the output register for every operation.
// ----------------------------------------------------------------------------
module qau_rot_tail
  import qau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  mid_t mid_i,
  output logic done_o,
  output res_t res_o
);

  word_t c[3];
  word_t q[3];

  logic  valid_d_q;
  mid_t  mid_d_q;
  prod_t wc_q[3];
  prod_t pp_q[3];
  prod_t pn_q[3];

  logic  done_q;
  res_t  res_d;
  res_t  res_q;

  sat_t  rot_s[3];
  word_t v[3];

  assign c[IDX_X] = mid_i.c_x;
  assign c[IDX_Y] = mid_i.c_y;
  assign c[IDX_Z] = mid_i.c_z;
  assign q[IDX_X] = mid_i.q_x;
  assign q[IDX_Y] = mid_i.q_y;
  assign q[IDX_Z] = mid_i.q_z;

  // stage D: w*c and q x c products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_d_q <= 1'b0;
    end else begin
      valid_d_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_d_q <= mid_i;
    for (int i = 0; i < 3; i++) begin
      wc_q[i] <= mid_i.q_w * c[i];
    end
    pp_q[IDX_X] <= q[IDX_Y] * c[IDX_Z];
    pn_q[IDX_X] <= q[IDX_Z] * c[IDX_Y];
    pp_q[IDX_Y] <= q[IDX_Z] * c[IDX_X];
    pn_q[IDX_Y] <= q[IDX_X] * c[IDX_Z];
    pp_q[IDX_Z] <= q[IDX_X] * c[IDX_Y];
    pn_q[IDX_Z] <= q[IDX_Y] * c[IDX_X];
  end

  // stage E: v + 2*(w*c + q x c), one rounding
  assign v[IDX_X] = mid_d_q.v_x;
  assign v[IDX_Y] = mid_d_q.v_y;
  assign v[IDX_Z] = mid_d_q.v_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_s[i] = sat_word(round_frac((acc_t'(v[i]) <<< FRACTION_BITS)
                                     + (acc_t'(wc_q[i]) <<< 1)
                                     + (acc_t'(pp_q[i]) <<< 1)
                                     - (acc_t'(pn_q[i]) <<< 1)));
    end
    if (mid_d_q.func == FUNC_ROTATE) begin
      res_d.x   = rot_s[IDX_X].val;
      res_d.y   = rot_s[IDX_Y].val;
      res_d.z   = rot_s[IDX_Z].val;
      res_d.w   = '0;
      res_d.ovf = mid_d_q.ovf | rot_s[IDX_X].ovf | rot_s[IDX_Y].ovf | rot_s[IDX_Z].ovf;
    end else begin
      res_d.x   = mid_d_q.res_x;
      res_d.y   = mid_d_q.res_y;
      res_d.z   = mid_d_q.res_z;
      res_d.w   = mid_d_q.res_w;
      res_d.ovf = mid_d_q.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
